/* hdl/ipv6p_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 text address parser package
// Shared types and character constants for the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

  localparam int unsigned NumGroups = 8;

  localparam logic [3:0] GroupsFull  = 4'd8;
  localparam logic [2:0] DigitsFull  = 3'd4;

  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] LetterBase = 8'd10;

  typedef logic [15:0] group_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    group_t group_0;
    group_t group_1;
    group_t group_2;
    group_t group_3;
    group_t group_4;
    group_t group_5;
    group_t group_6;
    group_t group_7;
    logic   parse_error;
  } out_item_t;

  // Decoded form of one character.
  typedef struct packed {
    logic       is_colon;
    logic       is_hex;
    logic [3:0] nibble;
  } char_class_t;

  // Running parse state for one address.
  typedef struct packed {
    group_t [NumGroups-1:0] group_store;
    group_t                 digit_accumulator;
    logic [2:0]             digit_count;
    logic [3:0]             groups_done;
    logic [3:0]             gap_position;
    logic                   gap_seen;
    logic                   prev_was_colon;
    logic                   error_seen;
  } parse_state_t;

endpackage

/* hdl/ipv6p_char_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 parser character decoder
// Classifies one ASCII character as colon, hex digit or other, with its value.
// ----------------------------------------------------------------------------
module ipv6p_char_decode (
  input  logic [7:0]             char_code_i,
  output ipv6p_pkg::char_class_t class_o
);

  logic       is_digit;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] digit_val;
  logic [7:0] upper_val;
  logic [7:0] lower_val;

  always_comb begin
    is_digit  = (char_code_i >= ipv6p_pkg::ChZero)   && (char_code_i <= ipv6p_pkg::ChNine);
    is_upper  = (char_code_i >= ipv6p_pkg::ChUpperA) && (char_code_i <= ipv6p_pkg::ChUpperF);
    is_lower  = (char_code_i >= ipv6p_pkg::ChLowerA) && (char_code_i <= ipv6p_pkg::ChLowerF);
    digit_val = char_code_i - ipv6p_pkg::ChZero;
    upper_val = char_code_i - ipv6p_pkg::ChUpperA + ipv6p_pkg::LetterBase;
    lower_val = char_code_i - ipv6p_pkg::ChLowerA + ipv6p_pkg::LetterBase;

    class_o.is_colon = (char_code_i == ipv6p_pkg::ChColon);
    class_o.is_hex   = is_digit || is_upper || is_lower;
    if (is_digit) begin
      class_o.nibble = digit_val[3:0];
    end else if (is_upper) begin
      class_o.nibble = upper_val[3:0];
    end else begin
      class_o.nibble = lower_val[3:0];
    end
  end

endmodule

/* hdl/ipv6p_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 parser step logic
// Folds one decoded character into the parse state and, on the final
// character, closes the open group and checks the group count.
// ----------------------------------------------------------------------------
module ipv6p_step (
  input  ipv6p_pkg::parse_state_t state_i,
  input  ipv6p_pkg::char_class_t  class_i,
  input  logic                    last_i,
  output ipv6p_pkg::parse_state_t state_o
);

  function automatic ipv6p_pkg::parse_state_t close_group(ipv6p_pkg::parse_state_t s);
    ipv6p_pkg::parse_state_t r;
    r = s;
    if (r.groups_done >= ipv6p_pkg::GroupsFull) begin
      r.error_seen = 1'b1;
    end else begin
      r.group_store[r.groups_done[2:0]] = r.digit_accumulator;
      r.groups_done = r.groups_done + 4'd1;
    end
    r.digit_accumulator = '0;
    r.digit_count       = '0;
    return r;
  endfunction

  ipv6p_pkg::parse_state_t s;

  always_comb begin
    s = state_i;

    if (!s.error_seen) begin
      if (class_i.is_colon) begin
        if (s.prev_was_colon) begin
          // Second colon of a "::" gap; only one gap is allowed.
          if (s.gap_seen) begin
            s.error_seen = 1'b1;
          end
          s.gap_seen       = 1'b1;
          s.gap_position   = s.groups_done;
          s.prev_was_colon = 1'b0;
        end else if (s.digit_count != 3'd0) begin
          s                = close_group(s);
          s.prev_was_colon = 1'b1;
        end else if ((s.groups_done == 4'd0) && !s.gap_seen) begin
          s.prev_was_colon = 1'b1;
        end else begin
          s.error_seen = 1'b1;
        end
      end else if (!class_i.is_hex) begin
        s.error_seen = 1'b1;
      end else begin
        // A lone leading colon followed by a digit is malformed.
        if (s.prev_was_colon && (s.groups_done == 4'd0) && !s.gap_seen) begin
          s.error_seen = 1'b1;
        end
        s.prev_was_colon = 1'b0;
        if (s.digit_count >= ipv6p_pkg::DigitsFull) begin
          s.error_seen = 1'b1;
        end else begin
          s.digit_accumulator = {s.digit_accumulator[11:0], class_i.nibble};
          s.digit_count       = s.digit_count + 3'd1;
        end
      end
    end

    if (last_i && !s.error_seen) begin
      if (s.prev_was_colon) begin
        s.error_seen = 1'b1;
      end else if (s.digit_count != 3'd0) begin
        s = close_group(s);
      end
    end

    if (last_i && !s.error_seen) begin
      if (s.gap_seen) begin
        if ((s.groups_done > 4'd7) || (s.gap_position > s.groups_done)) begin
          s.error_seen = 1'b1;
        end
      end else if (s.groups_done != ipv6p_pkg::GroupsFull) begin
        s.error_seen = 1'b1;
      end
    end

    state_o = s;
  end

endmodule

/* hdl/ipv6p_group_expand.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 parser gap expansion
// Places the stored groups into eight output slots, filling the "::" gap
// with zero groups, and zeroes everything on an error.
// ----------------------------------------------------------------------------
module ipv6p_group_expand (
  input  ipv6p_pkg::parse_state_t state_i,
  output ipv6p_pkg::out_item_t    item_o
);

  ipv6p_pkg::group_t res [ipv6p_pkg::NumGroups];
  logic [3:0] after;

  always_comb begin
    logic [4:0] slot;
    logic [4:0] reach;
    logic [3:0] src;
    slot  = '0;
    reach = '0;
    src   = '0;
    after = state_i.groups_done - state_i.gap_position;
    for (int i = 0; i < ipv6p_pkg::NumGroups; i++) begin
      slot  = 5'(i);
      reach = slot + {1'b0, after};
      // Source of a slot right of the gap: i + groups_done - 8.
      src   = 4'(i) + state_i.groups_done - ipv6p_pkg::GroupsFull;
      res[i] = '0;
      if (!state_i.error_seen) begin
        if (!state_i.gap_seen) begin
          res[i] = state_i.group_store[i];
        end else if (slot < {1'b0, state_i.gap_position}) begin
          res[i] = state_i.group_store[i];
        end else if (reach >= 5'(ipv6p_pkg::NumGroups)) begin
          res[i] = state_i.group_store[src[2:0]];
        end
      end
    end

    item_o.group_0     = res[0];
    item_o.group_1     = res[1];
    item_o.group_2     = res[2];
    item_o.group_3     = res[3];
    item_o.group_4     = res[4];
    item_o.group_5     = res[5];
    item_o.group_6     = res[6];
    item_o.group_7     = res[7];
    item_o.parse_error = state_i.error_seen;
  end

endmodule

/* hdl/ipv6_text_address_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 text address parser
// Parses an IPv6 address given as a character stream into eight 16-bit groups.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one ASCII character per transaction, with
//   last_char set on the final character of an address. The output channel
//   carries one transaction per address: the eight groups, group_0 first, and
//   parse_error. On an error all groups read as zero.
//   A transaction is taken into an input register, then decoded and folded
//   into the parse state. A final character writes the result register, so
//   a result is valid once the last character has passed through the input
//   register and the result register. One character is accepted every cycle
//   while ready is high. When the receiver stalls, the held result blocks
//   only a further final character; ordinary characters keep flowing into
//   the parse state. Ready drops once a final character waits in the input
//   register behind an untaken result.
//   Reset clears the parse state, the input valid and the result valid.
//   After each result the parse state, but for the group store, returns to
//   its reset contents, ready for the next address.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ipv6p_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ipv6p_pkg::out_item_t out_item_o
);

  // Input register.
  logic                    in_valid_q;
  ipv6p_pkg::in_item_t     in_q;

  // Parse state.
  ipv6p_pkg::parse_state_t state_q;
  ipv6p_pkg::parse_state_t state_d;
  ipv6p_pkg::parse_state_t state_next;

  // Result register.
  logic                    out_valid_q;
  ipv6p_pkg::out_item_t    out_q;
  ipv6p_pkg::out_item_t    result;

  ipv6p_pkg::char_class_t  char_class;
  logic                    advance;

  // The held character is processed unless it would produce a result while
  // the result register still holds one that has not been taken.
  assign advance    = in_valid_q && (!in_q.last_char || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ipv6p_char_decode u_decode (
    .char_code_i (in_q.char_code),
    .class_o     (char_class)
  );

  ipv6p_step u_step (
    .state_i (state_q),
    .class_i (char_class),
    .last_i  (in_q.last_char),
    .state_o (state_next)
  );

  ipv6p_group_expand u_expand (
    .state_i (state_next),
    .item_o  (result)
  );

  // After the final character the control state starts over. The group
  // store keeps its contents; only groups written for the new address are
  // ever read.
  always_comb begin
    state_d = state_next;
    if (in_q.last_char) begin
      state_d             = '0;
      state_d.group_store = state_next.group_store;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last_char) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_char) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
